FILE: rtl/dat_pkg.sv
// Shared types and constants for the DCM attitude sine/cosine block.
// No dependencies; dcm_attitude_trig and the testbench import this package.
`timescale 1ns / 1ps

package dat_pkg;

  localparam int FRAC_BITS = 14;

  // square root unit: radicand width, root width (one extra bit for rounding)
  localparam int SQRT_IN_W  = 48;
  localparam int SQRT_OUT_W = SQRT_IN_W / 2 + 1;
  localparam int SQRT_LAT   = SQRT_IN_W / 2 + 1;

  // divider unit: quotient bits, one stage per bit
  localparam int DIV_Q_W = 15;
  localparam int DIV_LAT = DIV_Q_W;

  localparam logic [DIV_Q_W-1:0] ONE_Q  = DIV_Q_W'(1 << FRAC_BITS);
  localparam logic [31:0]        ONE_SQ = 32'd1 << (2 * FRAC_BITS);

  typedef struct packed {
    logic signed [15:0] dcm_ax;
    logic signed [15:0] dcm_bx;
    logic signed [15:0] dcm_cx;
    logic signed [15:0] dcm_cy;
    logic signed [15:0] dcm_cz;
  } dcm_t;

  typedef struct packed {
    logic signed [15:0] sin_yaw;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] pitch_sin;
    logic        [14:0] pitch_cos;
    logic signed [15:0] roll_sin;
    logic signed [15:0] roll_cos;
    logic               roll_saturated;
  } trig_t;

endpackage

FILE: rtl/dat_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// Carries a sideband word alongside. Depends on nothing outside this file.
`timescale 1ns / 1ps

module dat_sqrt_pipe #(
  parameter int IN_W = 48,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   radicand,
  input  logic [SB_W-1:0]   sb_in,
  output logic [IN_W/2:0]   root,
  output logic [SB_W-1:0]   sb_out
);

  localparam int OW = IN_W / 2;
  localparam int RW = OW + 2;

  logic [RW-1:0]   rem_r  [OW];
  logic [OW-1:0]   q_r    [OW];
  logic [IN_W-1:0] val_r  [OW];
  logic [SB_W-1:0] sb_r   [OW];

  logic [RW-1:0]   rem_next [OW];
  logic [OW-1:0]   q_next   [OW];
  logic [IN_W-1:0] val_next [OW];
  logic            round_up;

  always_comb begin
    logic [RW-1:0]   r_in;
    logic [OW-1:0]   q_in;
    logic [IN_W-1:0] v_in;
    logic [RW-1:0]   rs;
    logic [RW-1:0]   t;
    for (int k = 0; k < OW; k++) begin
      if (k == 0) begin
        r_in = '0;
        q_in = '0;
        v_in = radicand;
      end else begin
        r_in = rem_r[k-1];
        q_in = q_r[k-1];
        v_in = val_r[k-1];
      end
      rs = {r_in[RW-3:0], v_in[IN_W-1 -: 2]};
      t  = {q_in, 2'b01};
      if (rs >= t) begin
        rem_next[k] = rs - t;
        q_next[k]   = {q_in[OW-2:0], 1'b1};
      end else begin
        rem_next[k] = rs;
        q_next[k]   = {q_in[OW-2:0], 1'b0};
      end
      val_next[k] = {v_in[IN_W-3:0], 2'b00};
    end
    // remainder is v - q^2; above q means the root is nearer q+1
    round_up = rem_r[OW-1] > {2'b00, q_r[OW-1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < OW; k++) begin
        rem_r[k] <= rem_next[k];
        q_r[k]   <= q_next[k];
        val_r[k] <= val_next[k];
      end
      sb_r[0] <= sb_in;
      for (int k = 1; k < OW; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      root   <= {1'b0, q_r[OW-1]} + {{OW{1'b0}}, round_up};
      sb_out <= sb_r[OW-1];
    end
  end

endmodule

FILE: rtl/dat_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Expects num < den * 2^QW; carries a sideband word. No other dependencies.
`timescale 1ns / 1ps

module dat_div_pipe #(
  parameter int NW   = 39,
  parameter int DW   = 25,
  parameter int QW   = 15,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   num,
  input  logic [DW-1:0]   den,
  input  logic [SB_W-1:0] sb_in,
  output logic [QW-1:0]   quo,
  output logic [SB_W-1:0] sb_out
);

  logic [DW-1:0]   rem_r [QW];
  logic [DW-1:0]   den_r [QW];
  logic [QW-1:0]   lo_r  [QW];
  logic [QW-1:0]   q_r   [QW];
  logic [SB_W-1:0] sb_r  [QW];

  logic [DW-1:0] rem_next [QW];
  logic [QW-1:0] lo_next  [QW];
  logic [QW-1:0] q_next   [QW];

  always_comb begin
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   rs;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        r_in  = DW'(num[NW-1:QW]);
        d_in  = den;
        lo_in = num[QW-1:0];
        q_in  = '0;
      end else begin
        r_in  = rem_r[k-1];
        d_in  = den_r[k-1];
        lo_in = lo_r[k-1];
        q_in  = q_r[k-1];
      end
      rs = {r_in, lo_in[QW-1]};
      if (rs >= {1'b0, d_in}) begin
        rem_next[k] = DW'(rs - {1'b0, d_in});
        q_next[k]   = {q_in[QW-2:0], 1'b1};
      end else begin
        rem_next[k] = DW'(rs);
        q_next[k]   = {q_in[QW-2:0], 1'b0};
      end
      lo_next[k] = {lo_in[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_next[k];
        lo_r[k]  <= lo_next[k];
        q_r[k]   <= q_next[k];
      end
      den_r[0] <= den;
      sb_r[0]  <= sb_in;
      for (int k = 1; k < QW; k++) begin
        den_r[k] <= den_r[k-1];
        sb_r[k]  <= sb_r[k-1];
      end
    end
  end

  assign quo    = q_r[QW-1];
  assign sb_out = sb_r[QW-1];

endmodule

FILE: rtl/dcm_attitude_trig.sv
// Sine and cosine of yaw, pitch and roll from five DCM entries (Q1.14).
// Pipeline depth: 44 register stages; one transfer per cycle while the output is not
// stalled.
// Pipeline: squares, sums, 25-stage rounded square roots (24 root bits plus rounding),
// operand setup, 15-stage dividers, output register. An output stall with a result
// waiting holds the whole pipe.
// Reset (rst, synchronous) clears every valid bit; data registers are not reset.
// Uses dat_pkg, dat_sqrt_pipe, dat_div_pipe.
`timescale 1ns / 1ps

module dcm_attitude_trig (
  input  logic           clk,
  input  logic           rst,
  input  logic           dcm_valid,
  output logic           dcm_stall,
  input  dat_pkg::dcm_t  dcm,
  output logic           trig_valid,
  input  logic           trig_stall,
  output dat_pkg::trig_t trig
);

  import dat_pkg::*;

  localparam int CORE_LAT = SQRT_LAT + 1 + DIV_LAT;
  localparam int YN_W     = 16 + FRAC_BITS + 9;  // yaw numerator
  localparam int RN_W     = 16 + FRAC_BITS + 1;  // roll numerator

  function automatic logic signed [15:0] apply_sign(input logic [DIV_Q_W-1:0] q,
                                                    input logic neg);
    logic [DIV_Q_W-1:0] m;
    m = (q > ONE_Q) ? ONE_Q : q;
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  logic en;
  assign en        = !trig_valid || !trig_stall;
  assign dcm_stall = !en;

  // valid bits
  logic                s1_vld;
  logic                s2_vld;
  logic [CORE_LAT-1:0] vld_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld     <= 1'b0;
      s2_vld     <= 1'b0;
      vld_pipe   <= '0;
      trig_valid <= 1'b0;
    end else if (en) begin
      s1_vld     <= dcm_valid;
      s2_vld     <= s1_vld;
      vld_pipe   <= {vld_pipe[CORE_LAT-2:0], s2_vld};
      trig_valid <= vld_pipe[CORE_LAT-1];
    end
  end

  // stage 1: magnitudes and squares
  logic [15:0]        mag_ax, mag_bx, mag_cx, mag_cy, mag_cz;
  logic signed [15:0] pitch_sin_c;

  always_comb begin
    mag_ax = dcm.dcm_ax[15] ? 16'(~dcm.dcm_ax + 16'd1) : dcm.dcm_ax;
    mag_bx = dcm.dcm_bx[15] ? 16'(~dcm.dcm_bx + 16'd1) : dcm.dcm_bx;
    mag_cx = dcm.dcm_cx[15] ? 16'(~dcm.dcm_cx + 16'd1) : dcm.dcm_cx;
    mag_cy = dcm.dcm_cy[15] ? 16'(~dcm.dcm_cy + 16'd1) : dcm.dcm_cy;
    mag_cz = dcm.dcm_cz[15] ? 16'(~dcm.dcm_cz + 16'd1) : dcm.dcm_cz;
    // negating the most negative entry saturates
    pitch_sin_c = (dcm.dcm_cx == 16'sh8000) ? 16'sh7FFF : -dcm.dcm_cx;
  end

  logic [15:0]        s1_mag_ax, s1_mag_bx, s1_mag_cy, s1_mag_cz;
  logic               s1_ax_neg, s1_bx_neg, s1_cy_neg, s1_cy_zero, s1_cz_neg, s1_cz_zero;
  logic [31:0]        s1_ax2, s1_bx2, s1_cx2;
  logic signed [15:0] s1_pitch_sin;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_ax    <= mag_ax;
      s1_mag_bx    <= mag_bx;
      s1_mag_cy    <= mag_cy;
      s1_mag_cz    <= mag_cz;
      s1_ax_neg    <= dcm.dcm_ax[15];
      s1_bx_neg    <= dcm.dcm_bx[15];
      s1_cy_neg    <= dcm.dcm_cy[15];
      s1_cz_neg    <= dcm.dcm_cz[15];
      s1_cy_zero   <= (dcm.dcm_cy == 16'sd0);
      s1_cz_zero   <= (dcm.dcm_cz == 16'sd0);
      s1_ax2       <= 32'(mag_ax) * 32'(mag_ax);
      s1_bx2       <= 32'(mag_bx) * 32'(mag_bx);
      s1_cx2       <= 32'(mag_cx) * 32'(mag_cx);
      s1_pitch_sin <= pitch_sin_c;
    end
  end

  // stage 2: yaw length squared, 1 - cx^2 (zero when cx^2 reaches one)
  logic [31:0]              s2_len2;
  logic [2*FRAC_BITS:0]     s2_rem;
  logic                     s2_yaw_zero;
  logic [15:0]              s2_mag_ax, s2_mag_bx, s2_mag_cy, s2_mag_cz;
  logic                     s2_ax_neg, s2_bx_neg, s2_cy_neg, s2_cy_zero, s2_cz_neg, s2_cz_zero;
  logic signed [15:0]       s2_pitch_sin;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_len2      <= s1_ax2 + s1_bx2;
      s2_rem       <= (s1_cx2 < ONE_SQ) ? (2*FRAC_BITS+1)'(ONE_SQ - s1_cx2) : '0;
      s2_yaw_zero  <= (s1_ax2 == 32'd0) && (s1_bx2 == 32'd0);
      s2_mag_ax    <= s1_mag_ax;
      s2_mag_bx    <= s1_mag_bx;
      s2_mag_cy    <= s1_mag_cy;
      s2_mag_cz    <= s1_mag_cz;
      s2_ax_neg    <= s1_ax_neg;
      s2_bx_neg    <= s1_bx_neg;
      s2_cy_neg    <= s1_cy_neg;
      s2_cy_zero   <= s1_cy_zero;
      s2_cz_neg    <= s1_cz_neg;
      s2_cz_zero   <= s1_cz_zero;
      s2_pitch_sin <= s1_pitch_sin;
    end
  end

  // square roots
  localparam int YSB_W = 35;
  localparam int PSB_W = 52;

  logic [SQRT_OUT_W-1:0] root_y, root_p;
  logic [YSB_W-1:0]      ysb_out;
  logic [PSB_W-1:0]      psb_out;

  dat_sqrt_pipe #(.IN_W(SQRT_IN_W), .SB_W(YSB_W)) u_sqrt_yaw (
    .clk      (clk),
    .en       (en),
    .radicand ({s2_len2, 16'd0}),
    .sb_in    ({s2_ax_neg, s2_bx_neg, s2_yaw_zero, s2_mag_ax, s2_mag_bx}),
    .root     (root_y),
    .sb_out   (ysb_out)
  );

  dat_sqrt_pipe #(.IN_W(SQRT_IN_W), .SB_W(PSB_W)) u_sqrt_pitch (
    .clk      (clk),
    .en       (en),
    .radicand (SQRT_IN_W'(s2_rem)),
    .sb_in    ({s2_pitch_sin, s2_cy_neg, s2_cy_zero, s2_mag_cy,
                s2_cz_neg, s2_cz_zero, s2_mag_cz}),
    .root     (root_p),
    .sb_out   (psb_out)
  );

  logic               q_ax_neg, q_bx_neg, q_yaw_zero;
  logic [15:0]        q_mag_ax, q_mag_bx, q_mag_cy, q_mag_cz;
  logic signed [15:0] q_pitch_sin;
  logic               q_cy_neg, q_cy_zero, q_cz_neg, q_cz_zero;

  assign {q_ax_neg, q_bx_neg, q_yaw_zero, q_mag_ax, q_mag_bx} = ysb_out;
  assign {q_pitch_sin, q_cy_neg, q_cy_zero, q_mag_cy, q_cz_neg, q_cz_zero, q_mag_cz} = psb_out;

  // operand setup: rounding offsets, pitch clamp, roll overflow precheck
  logic [DIV_Q_W-1:0] cp_c;
  logic [YN_W-1:0]    num_ax_c, num_bx_c;
  logic [RN_W-1:0]    num_cy_c, num_cz_c;

  always_comb begin
    cp_c     = (root_p > SQRT_OUT_W'(ONE_Q)) ? ONE_Q : root_p[DIV_Q_W-1:0];
    num_ax_c = (YN_W'(q_mag_ax) << (FRAC_BITS + 8)) + YN_W'(root_y >> 1);
    num_bx_c = (YN_W'(q_mag_bx) << (FRAC_BITS + 8)) + YN_W'(root_y >> 1);
    num_cy_c = (RN_W'(q_mag_cy) << FRAC_BITS) + RN_W'(cp_c >> 1);
    num_cz_c = (RN_W'(q_mag_cz) << FRAC_BITS) + RN_W'(cp_c >> 1);
  end

  logic [YN_W-1:0]       m_num_ax, m_num_bx;
  logic [RN_W-1:0]       m_num_cy, m_num_cz;
  logic [SQRT_OUT_W-1:0] m_len;
  logic [DIV_Q_W-1:0]    m_cp;
  logic                  m_cp_zero, m_ovf_s, m_ovf_c;
  logic                  m_ax_neg, m_bx_neg, m_yaw_zero;
  logic                  m_cy_neg, m_cy_zero, m_cz_neg, m_cz_zero;
  logic signed [15:0]    m_pitch_sin;

  always_ff @(posedge clk) begin
    if (en) begin
      m_num_ax    <= num_ax_c;
      m_num_bx    <= num_bx_c;
      m_num_cy    <= num_cy_c;
      m_num_cz    <= num_cz_c;
      m_len       <= root_y;
      m_cp        <= cp_c;
      m_cp_zero   <= (cp_c == '0);
      // quotient of 2^15 or more cannot fit the divider
      m_ovf_s     <= num_cy_c >= (RN_W'(cp_c) << DIV_Q_W);
      m_ovf_c     <= num_cz_c >= (RN_W'(cp_c) << DIV_Q_W);
      m_ax_neg    <= q_ax_neg;
      m_bx_neg    <= q_bx_neg;
      m_yaw_zero  <= q_yaw_zero;
      m_cy_neg    <= q_cy_neg;
      m_cy_zero   <= q_cy_zero;
      m_cz_neg    <= q_cz_neg;
      m_cz_zero   <= q_cz_zero;
      m_pitch_sin <= q_pitch_sin;
    end
  end

  // dividers
  logic [DIV_Q_W-1:0] quo_cy, quo_sy, quo_cr, quo_sr;
  logic [30:0]        sb_cy;
  logic [2:0]         sb_sy;
  logic [3:0]         sb_cr;
  logic [3:0]         sb_sr;

  dat_div_pipe #(.NW(YN_W), .DW(SQRT_OUT_W), .QW(DIV_Q_W), .SB_W(31)) u_div_cos_yaw (
    .clk (clk), .en (en), .num (m_num_ax), .den (m_len),
    .sb_in ({m_pitch_sin, m_cp}), .quo (quo_cy), .sb_out (sb_cy)
  );

  dat_div_pipe #(.NW(YN_W), .DW(SQRT_OUT_W), .QW(DIV_Q_W), .SB_W(3)) u_div_sin_yaw (
    .clk (clk), .en (en), .num (m_num_bx), .den (m_len),
    .sb_in ({m_yaw_zero, m_ax_neg, m_bx_neg}), .quo (quo_sy), .sb_out (sb_sy)
  );

  dat_div_pipe #(.NW(RN_W), .DW(DIV_Q_W), .QW(DIV_Q_W), .SB_W(4)) u_div_roll_cos (
    .clk (clk), .en (en), .num (m_num_cz), .den (m_cp),
    .sb_in ({m_cz_neg, m_cz_zero, m_ovf_c, m_cp_zero}), .quo (quo_cr), .sb_out (sb_cr)
  );

  dat_div_pipe #(.NW(RN_W), .DW(DIV_Q_W), .QW(DIV_Q_W), .SB_W(4)) u_div_roll_sin (
    .clk (clk), .en (en), .num (m_num_cy), .den (m_cp),
    .sb_in ({m_cy_neg, m_cy_zero, m_ovf_s, m_cp_zero}), .quo (quo_sr), .sb_out (sb_sr)
  );

  // final clamp and sign
  logic signed [15:0] d_pitch_sin;
  logic [14:0]        d_cp;
  logic               d_yaw_zero, d_ax_neg, d_bx_neg;
  logic               d_cz_neg, d_cz_zero, d_ovf_c, d_cpz_c;
  logic               d_cy_neg, d_cy_zero, d_ovf_s, d_cpz_s;
  trig_t              trig_c;

  assign {d_pitch_sin, d_cp}                     = sb_cy;
  assign {d_yaw_zero, d_ax_neg, d_bx_neg}        = sb_sy;
  assign {d_cz_neg, d_cz_zero, d_ovf_c, d_cpz_c} = sb_cr;
  assign {d_cy_neg, d_cy_zero, d_ovf_s, d_cpz_s} = sb_sr;

  always_comb begin
    trig_c.sin_yaw   = d_yaw_zero ? 16'sd0 : apply_sign(quo_sy, d_bx_neg);
    trig_c.cos_yaw   = d_yaw_zero ? 16'sd0 : apply_sign(quo_cy, d_ax_neg);
    trig_c.pitch_sin = d_pitch_sin;
    trig_c.pitch_cos = d_cp;
    if (d_cpz_c) begin
      trig_c.roll_cos = d_cz_zero ? 16'sd0 : apply_sign(ONE_Q, d_cz_neg);
    end else begin
      trig_c.roll_cos = apply_sign(d_ovf_c ? ONE_Q : quo_cr, d_cz_neg);
    end
    if (d_cpz_s) begin
      trig_c.roll_sin = d_cy_zero ? 16'sd0 : apply_sign(ONE_Q, d_cy_neg);
    end else begin
      trig_c.roll_sin = apply_sign(d_ovf_s ? ONE_Q : quo_sr, d_cy_neg);
    end
    trig_c.roll_saturated = d_cpz_s || d_ovf_s || (quo_sr > ONE_Q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig <= trig_c;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for dcm_attitude_trig: drives DCM entries, predicts yaw/pitch/roll sin/cos.
// Depends on dat_pkg and the dcm_attitude_trig RTL.
`timescale 1ns / 1ps

module tb_top;
  import dat_pkg::*;

  localparam longint ONE = 64'd1 << FRAC_BITS;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic dcm_valid = 1'b0;
  logic dcm_stall;
  dcm_t dcm = '0;
  logic trig_valid;
  logic trig_stall = 1'b0;
  trig_t trig;

  trig_t angle_q[$];
  int mismatches = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_sat = 0;
  int cycles = 0;
  bit hold_long = 0;
  bit stall_quiet = 0;

  dcm_attitude_trig dut (
    .clk(clk), .rst(rst), .dcm_valid(dcm_valid), .dcm_stall(dcm_stall), .dcm(dcm),
    .trig_valid(trig_valid), .trig_stall(trig_stall), .trig(trig)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint unsigned root_round(longint unsigned v);
    longint unsigned rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    if (v - res * res > res) res += 1;
    return res;
  endfunction

  function automatic longint unsigned quot_round(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint unsigned absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [15:0] signed_q(longint unsigned m, bit neg);
    longint v;
    v = neg ? -longint'(m) : longint'(m);
    return v[15:0];
  endfunction

  function automatic trig_t predict_angles(dcm_t d);
    trig_t r;
    longint ax, bx, cx, cy, cz, sp;
    longint unsigned len2, ls, mx, my, rem, cp, qc, qs;
    ax = d.dcm_ax; bx = d.dcm_bx; cx = d.dcm_cx; cy = d.dcm_cy; cz = d.dcm_cz;
    r = '0;
    len2 = absval(ax) * absval(ax) + absval(bx) * absval(bx);
    if (len2 != 0) begin
      ls = root_round(len2 << 16);
      mx = quot_round((absval(ax) * ONE) << 8, ls);
      my = quot_round((absval(bx) * ONE) << 8, ls);
      if (mx > ONE) mx = ONE;
      if (my > ONE) my = ONE;
      r.cos_yaw = signed_q(mx, ax < 0);
      r.sin_yaw = signed_q(my, bx < 0);
    end
    rem = (absval(cx) * absval(cx) < ONE * ONE) ? ONE * ONE - absval(cx) * absval(cx) : 0;
    cp = root_round(rem);
    if (cp > ONE) cp = ONE;
    r.pitch_cos = cp[14:0];
    sp = -cx;
    if (sp > 32767) sp = 32767;
    r.pitch_sin = sp[15:0];
    if (cp == 0) begin
      r.roll_cos = (cz > 0) ? signed_q(ONE, 0) : (cz < 0) ? signed_q(ONE, 1) : '0;
      r.roll_sin = (cy > 0) ? signed_q(ONE, 0) : (cy < 0) ? signed_q(ONE, 1) : '0;
      r.roll_saturated = 1'b1;
    end else begin
      qc = quot_round(absval(cz) * ONE, cp);
      qs = quot_round(absval(cy) * ONE, cp);
      if (qc > ONE) qc = ONE;
      if (qs > ONE) begin
        qs = ONE;
        r.roll_saturated = 1'b1;
      end
      r.roll_cos = signed_q(qc, cz < 0);
      r.roll_sin = signed_q(qs, cy < 0);
    end
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // receiver stall pattern; the long hold-off overrides it
  always @(posedge clk) begin
    if (hold_long) trig_stall <= 1'b1;
    else if (stall_quiet) trig_stall <= 1'b0;
    else if ($urandom_range(0, 39) == 0) trig_stall <= 1'b1;
    else if (trig_stall && $urandom_range(0, 3) != 0) trig_stall <= 1'b1;
    else trig_stall <= ($urandom_range(0, 5) == 0);
  end

  // result checker
  always @(posedge clk) begin
    trig_t exp;
    if (!rst && trig_valid && !trig_stall) begin
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", trig);
      end else begin
        exp = angle_q.pop_front();
        n_checked++;
        if (exp.roll_saturated) n_sat++;
        if (trig !== exp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch #%0d: exp sy=%0d cy=%0d sp=%0d cp=%0d sr=%0d cr=%0d sat=%0b",
              n_checked, exp.sin_yaw, exp.cos_yaw, exp.pitch_sin, exp.pitch_cos,
              exp.roll_sin, exp.roll_cos, exp.roll_saturated);
            $display("             got sy=%0d cy=%0d sp=%0d cp=%0d sr=%0d cr=%0d sat=%0b",
              trig.sin_yaw, trig.cos_yaw, trig.pitch_sin, trig.pitch_cos,
              trig.roll_sin, trig.roll_cos, trig.roll_saturated);
          end
        end
      end
    end
  end

  // one transfer; valid stays high across back-to-back items
  task automatic send_matrix(dcm_t d, bit keep_busy);
    int g;
    dcm_valid <= 1'b1;
    dcm <= d;
    angle_q.push_back(predict_angles(d));
    n_sent++;
    do @(posedge clk); while (dcm_stall);
    g = keep_busy ? 0 : gap_len();
    if (g > 0) begin
      dcm_valid <= 1'b0;
      dcm <= '0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 16'($signed($urandom_range(0, 32768)) - 16384);
      1: return 16'($urandom);
      2: return 16'($signed($urandom_range(0, 16)) - 8);
      3: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // near-unit-length rotation-like matrix: cy,cz scaled by the pitch cosine, cy by up to 3% more
  function automatic dcm_t rand_attitude();
    dcm_t d;
    real p, ro, y;
    p = ($urandom_range(0, 20000) / 20000.0 - 0.5) * 3.14159;
    ro = ($urandom_range(0, 20000) / 20000.0 - 0.5) * 6.28318;
    y = ($urandom_range(0, 20000) / 20000.0 - 0.5) * 6.28318;
    d.dcm_ax = 16'($rtoi(16384.0 * $cos(p) * $cos(y)));
    d.dcm_bx = 16'($rtoi(16384.0 * $cos(p) * $sin(y)));
    d.dcm_cx = 16'($rtoi(-16384.0 * $sin(p)));
    d.dcm_cy = 16'($rtoi(16384.0 * $cos(p) * $sin(ro) * (1.0 + $urandom_range(0, 3) / 100.0)));
    d.dcm_cz = 16'($rtoi(16384.0 * $cos(p) * $cos(ro)));
    return d;
  endfunction

  task automatic test_directed();
    logic [15:0] ex[7] = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF};
    dcm_t d;
    send_matrix('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0);             // zero yaw vector
    send_matrix('{16'sd16384, 16'sd0, 16'sd16384, 16'sd5, -16'sd3}, 0);    // |c.x| = one
    send_matrix('{-16'sd1, 16'sd1, -16'sd16384, 16'sd0, 16'sd0}, 0);       // zero divisor, zeros
    send_matrix('{16'sd0, 16'sd7, 16'sd20000, -16'sd9, 16'sd4}, 0);        // c.x beyond one
    send_matrix('{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000}, 0);   // most negative c.x
    send_matrix('{16'sd100, 16'sd100, 16'sd16380, 16'sd16000, 16'sd1}, 0); // sine overflow
    send_matrix('{16'sd11585, 16'sd11585, 16'sd11585, 16'sd8192, 16'sd8192}, 0);
    send_matrix('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0);
    for (int i = 0; i < 14; i++) begin
      d.dcm_ax = ex[i % 7]; d.dcm_bx = ex[(i + 2) % 7]; d.dcm_cx = ex[(i + 3) % 7];
      d.dcm_cy = ex[(i + 5) % 7]; d.dcm_cz = ex[(i + 1) % 7];
      send_matrix(d, 0);
    end
  endtask

  task automatic test_random(int n);
    dcm_t d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) d = rand_attitude();
      else begin
        d.dcm_ax = rand_entry(); d.dcm_bx = rand_entry(); d.dcm_cx = rand_entry();
        d.dcm_cy = rand_entry(); d.dcm_cz = rand_entry();
      end
      send_matrix(d, ($urandom_range(0, 4) == 0));
    end
  endtask

  task automatic test_back_to_back(int n);
    stall_quiet = 1;
    for (int i = 0; i < n; i++) send_matrix(rand_attitude(), 1);
    stall_quiet = 0;
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills
  task automatic test_backpressure();
    hold_long = 1;
    fork
      begin
        for (int i = 0; i < 80; i++) send_matrix(rand_attitude(), 1);
      end
      begin
        repeat (150) @(posedge clk);
        hold_long = 0;
      end
    join
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_back_to_back(60);
    test_backpressure();
    test_random(990);
    dcm_valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d matrices, checked %0d results (%0d with roll saturated)",
             n_sent, n_checked, n_sat);
    $display("covered zero yaw, |c.x|>=one, zero divisors, sine overflow, backpressure");
    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dat_pkg.sv
rtl/dat_sqrt_pipe.sv
rtl/dat_div_pipe.sv
rtl/dcm_attitude_trig.sv
tb/sv/tb_top.sv
